/* hw/rtl/two_wire_serial_target_core_macros.svh */
// Assertion macros shared by the checkers of the two-wire serial target core.
// Depends on nothing; each use expects clk and rst_n in scope.
`ifndef TWO_WIRE_SERIAL_TARGET_CORE_MACROS_SVH
`define TWO_WIRE_SERIAL_TARGET_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is applied.
`define TSC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("two_wire_serial_target_core: assertion failed");

// Next-cycle implication, disabled while reset is applied.
`define TSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("two_wire_serial_target_core: assertion failed");

`endif

/* hw/rtl/tsc_pkg.sv */
// Shared types and constants of the two-wire serial target core.
// Depends on nothing; tsc_ctrl, tsc_outq, the core top and the checker refer to it by scoped names.
package tsc_pkg;

    localparam int FIFO_DEPTH_DEF = 16;
    localparam int BYTE_W         = 8;
    localparam int FILL_W         = 5;
    localparam int STATE_W        = 3;
    localparam int CMD_W          = 3;
    localparam int BIT_W          = 4;
    localparam int IDLE_W         = 32;

    // Item commands.
    localparam logic [CMD_W-1:0] CMD_DATA_EDGE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CLK_RISE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PUSH      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP       = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_TICK      = 3'd5;

    // Bus states, as reported on bus_state.
    localparam logic [STATE_W-1:0] ST_IDLE   = 3'd0;
    localparam logic [STATE_W-1:0] ST_RW     = 3'd1;
    localparam logic [STATE_W-1:0] ST_ACK_RX = 3'd2;
    localparam logic [STATE_W-1:0] ST_RX     = 3'd3;
    localparam logic [STATE_W-1:0] ST_FIN_RX = 3'd4;
    localparam logic [STATE_W-1:0] ST_ACK_TX = 3'd5;
    localparam logic [STATE_W-1:0] ST_TX     = 3'd6;

    // Result of one item, apart from the popped byte, which the memory supplies later.
    typedef struct packed {
        logic                drive_enable;
        logic                drive_value;
        logic                host_ok;
        logic                pop;
        logic [FILL_W-1:0]   read_fill;
        logic [FILL_W-1:0]   send_fill;
        logic [STATE_W-1:0]  bus_state;
        logic [IDLE_W-1:0]   idle_ticks;
    } result_t;

endpackage

/* hw/rtl/tsc_ram.sv */
// Simple dual-port byte memory with a registered read, used for both FIFOs.
// Depends on nothing.
module tsc_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/tsc_ctrl.sv */
// Bus state machine, FIFO pointers and counters of the two-wire serial target.
// Depends on tsc_pkg; drives the ports of the two FIFO memories.
module tsc_ctrl #(
    parameter int FIFO_DEPTH = tsc_pkg::FIFO_DEPTH_DEF,
    parameter int PTR_W      = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              step,
    input  logic [tsc_pkg::CMD_W-1:0]         cmd,
    input  logic                              clk_level,
    input  logic                              data_level,
    input  logic [tsc_pkg::BYTE_W-1:0]        host_byte,
    input  logic                              host_last,
    input  logic [tsc_pkg::BYTE_W-1:0]        tx_rdata,
    output logic                              rx_wr_en,
    output logic [PTR_W-1:0]                  rx_wr_addr,
    output logic [tsc_pkg::BYTE_W-1:0]        rx_wr_data,
    output logic                              rx_rd_en,
    output logic [PTR_W-1:0]                  rx_rd_addr,
    output logic                              tx_wr_en,
    output logic [PTR_W-1:0]                  tx_wr_addr,
    output logic [tsc_pkg::BYTE_W-1:0]        tx_wr_data,
    output logic                              tx_rd_en,
    output logic [PTR_W-1:0]                  tx_rd_addr,
    output tsc_pkg::result_t                  result
);

    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

    logic [tsc_pkg::STATE_W-1:0] state_reg, state_next;
    logic                        fin_reg, fin_next;
    logic [tsc_pkg::BYTE_W-1:0]  shift_reg, shift_next, shift_eff;
    logic [tsc_pkg::BIT_W-1:0]   bit_reg, bit_next, bit_inc;
    logic [PTR_W-1:0]            rx_rd_ptr_reg, rx_rd_ptr_next;
    logic [PTR_W-1:0]            rx_wr_ptr_reg, rx_wr_ptr_next;
    logic [PTR_W-1:0]            tx_rd_ptr_reg, tx_rd_ptr_next;
    logic [PTR_W-1:0]            tx_wr_ptr_reg, tx_wr_ptr_next;
    logic [CNT_W-1:0]            rx_cnt_reg, rx_cnt_next;
    logic [CNT_W-1:0]            tx_cnt_reg, tx_cnt_next;
    logic                        drv_en_reg, drv_en_next;
    logic                        drv_val_reg, drv_val_next;
    logic                        open_reg, open_next;
    logic [tsc_pkg::IDLE_W-1:0]  idle_reg, idle_next;
    logic                        tx_pend_reg, tx_pend_next;
    logic                        host_ok;
    logic                        pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    // The send byte read at an acknowledge slot comes from the registered read.
    assign shift_eff = tx_pend_reg ? tx_rdata : shift_reg;
    assign bit_inc   = bit_reg + 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        fin_next       = fin_reg;
        shift_next     = shift_reg;
        bit_next       = bit_reg;
        rx_rd_ptr_next = rx_rd_ptr_reg;
        rx_wr_ptr_next = rx_wr_ptr_reg;
        tx_rd_ptr_next = tx_rd_ptr_reg;
        tx_wr_ptr_next = tx_wr_ptr_reg;
        rx_cnt_next    = rx_cnt_reg;
        tx_cnt_next    = tx_cnt_reg;
        drv_en_next    = drv_en_reg;
        drv_val_next   = drv_val_reg;
        open_next      = open_reg;
        idle_next      = idle_reg;
        tx_pend_next   = tx_pend_reg;
        host_ok        = 1'b0;
        pop            = 1'b0;
        rx_wr_en       = 1'b0;
        rx_rd_en       = 1'b0;
        tx_wr_en       = 1'b0;
        tx_rd_en       = 1'b0;
        if (step)
        begin
            shift_next   = shift_eff;
            tx_pend_next = 1'b0;
            case (cmd)
                tsc_pkg::CMD_DATA_EDGE:
                begin
                    idle_next = '0;
                    if (clk_level)
                    begin
                        drv_en_next  = 1'b0;
                        drv_val_next = 1'b0;
                        state_next   = (data_level || open_reg) ? tsc_pkg::ST_IDLE
                                                                : tsc_pkg::ST_RW;
                    end
                end
                tsc_pkg::CMD_CLK_RISE:
                begin
                    idle_next = '0;
                    case (state_reg)
                        tsc_pkg::ST_RW:
                        begin
                            drv_en_next  = 1'b0;
                            drv_val_next = 1'b0;
                            bit_next     = '0;
                            if (data_level)
                            begin
                                state_next = tsc_pkg::ST_ACK_RX;
                                shift_next = '0;
                            end
                            else
                            begin
                                state_next = tsc_pkg::ST_ACK_TX;
                            end
                        end
                        tsc_pkg::ST_ACK_RX:
                        begin
                            shift_next   = '0;
                            bit_next     = '0;
                            drv_val_next = 1'b0;
                            if (rx_cnt_reg >= CNT_FULL)
                            begin
                                drv_en_next = 1'b0;
                                state_next  = tsc_pkg::ST_IDLE;
                            end
                            else
                            begin
                                drv_en_next = 1'b1;
                                state_next  = tsc_pkg::ST_RX;
                            end
                        end
                        tsc_pkg::ST_RX:
                        begin
                            drv_en_next  = 1'b0;
                            drv_val_next = 1'b0;
                            shift_next   = shift_eff
                                         | (tsc_pkg::BYTE_W'(data_level) << bit_reg[2:0]);
                            bit_next     = bit_inc;
                            if (bit_inc >= tsc_pkg::BIT_W'(tsc_pkg::BYTE_W))
                            begin
                                if (rx_cnt_reg < CNT_FULL)
                                begin
                                    rx_wr_en       = 1'b1;
                                    rx_wr_ptr_next = ptr_inc(rx_wr_ptr_reg);
                                    rx_cnt_next    = rx_cnt_reg + 1'b1;
                                end
                                state_next = tsc_pkg::ST_FIN_RX;
                            end
                        end
                        tsc_pkg::ST_FIN_RX:
                        begin
                            drv_en_next  = 1'b0;
                            drv_val_next = 1'b0;
                            state_next   = data_level ? tsc_pkg::ST_IDLE : tsc_pkg::ST_ACK_RX;
                        end
                        tsc_pkg::ST_ACK_TX:
                        begin
                            drv_val_next = 1'b0;
                            if (tx_cnt_reg != '0)
                            begin
                                drv_en_next    = 1'b1;
                                tx_rd_en       = 1'b1;
                                tx_pend_next   = 1'b1;
                                tx_rd_ptr_next = ptr_inc(tx_rd_ptr_reg);
                                tx_cnt_next    = tx_cnt_reg - 1'b1;
                                bit_next       = '0;
                                fin_next       = 1'b0;
                                state_next     = tsc_pkg::ST_TX;
                            end
                            else
                            begin
                                drv_en_next = 1'b0;
                                state_next  = tsc_pkg::ST_IDLE;
                            end
                        end
                        tsc_pkg::ST_TX:
                        begin
                            if (!fin_reg)
                            begin
                                drv_en_next  = 1'b1;
                                drv_val_next = shift_eff[bit_reg[2:0]];
                                bit_next     = bit_inc;
                                if (bit_inc >= tsc_pkg::BIT_W'(tsc_pkg::BYTE_W))
                                begin
                                    fin_next = 1'b1;
                                end
                            end
                            else
                            begin
                                drv_en_next  = 1'b0;
                                drv_val_next = 1'b0;
                                state_next   = data_level ? tsc_pkg::ST_IDLE
                                                          : tsc_pkg::ST_ACK_TX;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                tsc_pkg::CMD_PUSH:
                begin
                    if (tx_cnt_reg < CNT_FULL)
                    begin
                        tx_wr_en       = 1'b1;
                        tx_wr_ptr_next = ptr_inc(tx_wr_ptr_reg);
                        tx_cnt_next    = tx_cnt_reg + 1'b1;
                        host_ok        = 1'b1;
                        open_next      = !host_last;
                    end
                end
                tsc_pkg::CMD_POP:
                begin
                    if (rx_cnt_reg != '0)
                    begin
                        rx_rd_en       = 1'b1;
                        rx_rd_ptr_next = ptr_inc(rx_rd_ptr_reg);
                        rx_cnt_next    = rx_cnt_reg - 1'b1;
                        host_ok        = 1'b1;
                        pop            = 1'b1;
                        open_next      = !host_last;
                    end
                end
                tsc_pkg::CMD_CLEAR:
                begin
                    rx_rd_ptr_next = '0;
                    rx_wr_ptr_next = '0;
                    tx_rd_ptr_next = '0;
                    tx_wr_ptr_next = '0;
                    rx_cnt_next    = '0;
                    tx_cnt_next    = '0;
                    state_next     = tsc_pkg::ST_IDLE;
                    drv_en_next    = 1'b0;
                    drv_val_next   = 1'b0;
                    open_next      = 1'b0;
                end
                tsc_pkg::CMD_TICK:
                begin
                    if (idle_reg != '1)
                    begin
                        idle_next = idle_reg + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign rx_wr_addr = rx_wr_ptr_reg;
    assign rx_wr_data = shift_next;
    assign rx_rd_addr = rx_rd_ptr_reg;
    assign tx_wr_addr = tx_wr_ptr_reg;
    assign tx_wr_data = host_byte;
    assign tx_rd_addr = tx_rd_ptr_reg;

    assign result.drive_enable = drv_en_next;
    assign result.drive_value  = drv_val_next;
    assign result.host_ok      = host_ok;
    assign result.pop          = pop;
    assign result.read_fill    = tsc_pkg::FILL_W'(rx_cnt_next);
    assign result.send_fill    = tsc_pkg::FILL_W'(tx_cnt_next);
    assign result.bus_state    = state_next;
    assign result.idle_ticks   = idle_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tsc_pkg::ST_IDLE;
            fin_reg       <= 1'b0;
            shift_reg     <= '0;
            bit_reg       <= '0;
            rx_rd_ptr_reg <= '0;
            rx_wr_ptr_reg <= '0;
            tx_rd_ptr_reg <= '0;
            tx_wr_ptr_reg <= '0;
            rx_cnt_reg    <= '0;
            tx_cnt_reg    <= '0;
            drv_en_reg    <= 1'b0;
            drv_val_reg   <= 1'b0;
            open_reg      <= 1'b0;
            idle_reg      <= '0;
            tx_pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fin_reg       <= fin_next;
            shift_reg     <= shift_next;
            bit_reg       <= bit_next;
            rx_rd_ptr_reg <= rx_rd_ptr_next;
            rx_wr_ptr_reg <= rx_wr_ptr_next;
            tx_rd_ptr_reg <= tx_rd_ptr_next;
            tx_wr_ptr_reg <= tx_wr_ptr_next;
            rx_cnt_reg    <= rx_cnt_next;
            tx_cnt_reg    <= tx_cnt_next;
            drv_en_reg    <= drv_en_next;
            drv_val_reg   <= drv_val_next;
            open_reg      <= open_next;
            idle_reg      <= idle_next;
            tx_pend_reg   <= tx_pend_next;
        end
    end

endmodule

/* hw/rtl/tsc_outq.sv */
// Two-stage result path: a stage that waits for the receive memory read,
// then the output register. Depends on tsc_pkg.
module tsc_outq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  tsc_pkg::result_t            res_in,
    input  logic [tsc_pkg::BYTE_W-1:0]  rx_rdata,
    output logic                        can_take,
    input  logic                        out_ready,
    output logic                        out_valid,
    output tsc_pkg::result_t            out_res,
    output logic [tsc_pkg::BYTE_W-1:0]  out_byte
);

    logic                       a_valid_reg, a_valid_next;
    tsc_pkg::result_t           a_res_reg;
    logic                       o_valid_reg, o_valid_next;
    tsc_pkg::result_t           o_res_reg;
    logic [tsc_pkg::BYTE_W-1:0] o_byte_reg;
    logic                       b_load;

    assign b_load   = a_valid_reg && (!o_valid_reg || out_ready);
    assign can_take = !a_valid_reg || b_load;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (load)
        begin
            a_valid_next = 1'b1;
        end
        else if (b_load)
        begin
            a_valid_next = 1'b0;
        end
        o_valid_next = o_valid_reg;
        if (b_load)
        begin
            o_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            o_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            a_res_reg <= res_in;
        end
        if (b_load)
        begin
            o_res_reg  <= a_res_reg;
            o_byte_reg <= a_res_reg.pop ? rx_rdata : '0;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_res   = o_res_reg;
    assign out_byte  = o_byte_reg;

endmodule

/* hw/rtl/two_wire_serial_target_core.sv */
// Two-wire serial target core: bus state machine, two byte FIFOs in memory, result path.
// Depends on tsc_pkg, tsc_ram, tsc_ctrl and tsc_outq.
//
// The core takes one event beat per clock while in_ready is high (a sampled data edge
// or clock rise on the two-wire link, a host push or pop, a clear or an idle tick) and
// returns one result beat for each, in order. An event is acted on in the cycle it is
// taken: the bus state machine, FIFO pointers and fill counts update at that edge, and
// the receive and send FIFOs live in two memories with a registered read. The
// result beat passes first a stage that covers the receive memory read for a pop, then
// the output register. Up to two results can wait downstream before in_ready drops, so
// with out_ready held high the sustained rate is one beat per cycle. A byte read from
// the send memory at an acknowledge slot is forwarded into the shifter for the following
// clock rise. Memory contents need no clearing after reset; the pointers and counts
// alone say what is valid.
module two_wire_serial_target_core #(
    parameter int FIFO_DEPTH = tsc_pkg::FIFO_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [tsc_pkg::CMD_W-1:0]      cmd,
    input  logic                           clk_level,
    input  logic                           data_level,
    input  logic [tsc_pkg::BYTE_W-1:0]     host_byte,
    input  logic                           host_last,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           drive_enable,
    output logic                           drive_value,
    output logic                           host_ok,
    output logic [tsc_pkg::BYTE_W-1:0]     host_byte_out,
    output logic [tsc_pkg::FILL_W-1:0]     read_fill,
    output logic [tsc_pkg::FILL_W-1:0]     send_fill,
    output logic [tsc_pkg::STATE_W-1:0]    bus_state,
    output logic [tsc_pkg::IDLE_W-1:0]     idle_ticks
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

    logic                       step;
    logic                       can_take;
    logic                       rx_wr_en, rx_rd_en, tx_wr_en, tx_rd_en;
    logic [PTR_W-1:0]           rx_wr_addr, rx_rd_addr, tx_wr_addr, tx_rd_addr;
    logic [tsc_pkg::BYTE_W-1:0] rx_wr_data, tx_wr_data, rx_rdata, tx_rdata;
    tsc_pkg::result_t           res_in;
    tsc_pkg::result_t           out_res;

    // An event beat is taken whenever the result path has room for its result.
    assign in_ready = can_take;
    assign step     = in_valid && can_take;

    tsc_ctrl #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .PTR_W      (PTR_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .cmd        (cmd),
        .clk_level  (clk_level),
        .data_level (data_level),
        .host_byte  (host_byte),
        .host_last  (host_last),
        .tx_rdata   (tx_rdata),
        .rx_wr_en   (rx_wr_en),
        .rx_wr_addr (rx_wr_addr),
        .rx_wr_data (rx_wr_data),
        .rx_rd_en   (rx_rd_en),
        .rx_rd_addr (rx_rd_addr),
        .tx_wr_en   (tx_wr_en),
        .tx_wr_addr (tx_wr_addr),
        .tx_wr_data (tx_wr_data),
        .tx_rd_en   (tx_rd_en),
        .tx_rd_addr (tx_rd_addr),
        .result     (res_in)
    );

    // Receive FIFO: written by the bus side, read by host pops.
    tsc_ram #(
        .DEPTH  (FIFO_DEPTH),
        .ADDR_W (PTR_W),
        .DATA_W (tsc_pkg::BYTE_W)
    ) u_rx_ram (
        .clk     (clk),
        .wr_en   (rx_wr_en),
        .wr_addr (rx_wr_addr),
        .wr_data (rx_wr_data),
        .rd_en   (rx_rd_en),
        .rd_addr (rx_rd_addr),
        .rd_data (rx_rdata)
    );

    // Send FIFO: written by host pushes, read at transmit acknowledge slots.
    tsc_ram #(
        .DEPTH  (FIFO_DEPTH),
        .ADDR_W (PTR_W),
        .DATA_W (tsc_pkg::BYTE_W)
    ) u_tx_ram (
        .clk     (clk),
        .wr_en   (tx_wr_en),
        .wr_addr (tx_wr_addr),
        .wr_data (tx_wr_data),
        .rd_en   (tx_rd_en),
        .rd_addr (tx_rd_addr),
        .rd_data (tx_rdata)
    );

    tsc_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step),
        .res_in    (res_in),
        .rx_rdata  (rx_rdata),
        .can_take  (can_take),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_res   (out_res),
        .out_byte  (host_byte_out)
    );

    assign drive_enable = out_res.drive_enable;
    assign drive_value  = out_res.drive_value;
    assign host_ok      = out_res.host_ok;
    assign read_fill    = out_res.read_fill;
    assign send_fill    = out_res.send_fill;
    assign bus_state    = out_res.bus_state;
    assign idle_ticks   = out_res.idle_ticks;

endmodule

/* hw/rtl/tsc_checker.sv */
// Port-level checks of the two-wire serial target core, bound to its top level.
// Depends on tsc_pkg and two_wire_serial_target_core_macros.svh.
`include "two_wire_serial_target_core_macros.svh"

module tsc_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic                           drive_enable,
    input logic                           drive_value,
    input logic                           host_ok,
    input logic [tsc_pkg::BYTE_W-1:0]     host_byte_out,
    input logic [tsc_pkg::STATE_W-1:0]    bus_state,
    input logic [tsc_pkg::IDLE_W-1:0]     idle_ticks
);

    // A driven high level is only ever reported together with the driver on.
    `TSC_ASSERT_IMPL(a_value_needs_drive, out_valid && drive_value, drive_enable)

    // A popped byte is only nonzero when the pop was granted.
    `TSC_ASSERT_IMPL(a_byte_needs_ok, out_valid && (host_byte_out != '0), host_ok)

    // The target only drives the line in a receive or transmit bit phase.
    `TSC_ASSERT_IMPL(a_drive_in_bit_phase, out_valid && drive_enable,
        (bus_state == tsc_pkg::ST_RX) || (bus_state == tsc_pkg::ST_TX))

    // A stalled result beat holds.
    `TSC_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready,
        out_valid && $stable(idle_ticks) && $stable(bus_state))

endmodule

bind two_wire_serial_target_core tsc_checker u_tsc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .drive_enable  (drive_enable),
    .drive_value   (drive_value),
    .host_ok       (host_ok),
    .host_byte_out (host_byte_out),
    .bus_state     (bus_state),
    .idle_ticks    (idle_ticks)
);

/* tb/tsc_link_checker.sv */
// Scoreboard for the two-wire serial target core: watches the event and result beats,
// keeps its own copy of the bus state machine and both byte FIFOs, and compares results.
// Depends on tsc_pkg for the command codes, bus states and field widths.
`timescale 1ns / 100ps

module tsc_link_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic [tsc_pkg::CMD_W-1:0]      cmd,
    input  logic                           clk_level,
    input  logic                           data_level,
    input  logic [tsc_pkg::BYTE_W-1:0]     host_byte,
    input  logic                           host_last,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic                           drive_enable,
    input  logic                           drive_value,
    input  logic                           host_ok,
    input  logic [tsc_pkg::BYTE_W-1:0]     host_byte_out,
    input  logic [tsc_pkg::FILL_W-1:0]     read_fill,
    input  logic [tsc_pkg::FILL_W-1:0]     send_fill,
    input  logic [tsc_pkg::STATE_W-1:0]    bus_state,
    input  logic [tsc_pkg::IDLE_W-1:0]     idle_ticks,
    output int                             mismatches,
    output int                             pending
);

    import tsc_pkg::*;

    localparam int DEPTH      = FIFO_DEPTH_DEF;
    localparam int PTR_W      = $clog2(DEPTH);

    typedef struct packed {
        logic                drive_enable;
        logic                drive_value;
        logic                host_ok;
        logic [BYTE_W-1:0]   host_byte_out;
        logic [FILL_W-1:0]   read_fill;
        logic [FILL_W-1:0]   send_fill;
        logic [STATE_W-1:0]  bus_state;
        logic [IDLE_W-1:0]   idle_ticks;
    } link_result_t;

    logic [STATE_W-1:0] link_state;
    logic               tx_tail_wait;   // In ST_TX: low while bits go out, high for the finish bit.
    logic [BYTE_W-1:0]  shifter;
    logic [BIT_W-1:0]   bit_pos;
    logic [BYTE_W-1:0]  rx_mem [DEPTH];
    logic [BYTE_W-1:0]  tx_mem [DEPTH];
    logic [PTR_W-1:0]   rx_head;
    logic [PTR_W-1:0]   tx_head;
    logic [FILL_W-1:0]  rx_fill;
    logic [FILL_W-1:0]  tx_fill;
    logic               line_en;
    logic               line_val;
    logic               host_hold;
    logic [IDLE_W-1:0]  idle_run;

    link_result_t expected_results[$];
    int           mismatch_total = 0;
    int           pending_total = 0;

    assign mismatches = mismatch_total;
    assign pending    = pending_total;

    // Applies one event to the local state and returns the result the core should give.
    function automatic link_result_t next_link_result(
        input logic [CMD_W-1:0]  op,
        input logic              ck,
        input logic              d,
        input logic [BYTE_W-1:0] b,
        input logic              last
    );
        link_result_t       r;
        logic [PTR_W-1:0]   slot;
        r = '0;
        case (op)
            CMD_DATA_EDGE: begin
                idle_run = '0;
                if (ck) begin
                    line_en    = 1'b0;
                    line_val   = 1'b0;
                    link_state = (d || host_hold) ? ST_IDLE : ST_RW;
                end
            end
            CMD_CLK_RISE: begin
                idle_run = '0;
                case (link_state)
                    ST_RW: begin
                        line_en  = 1'b0;
                        line_val = 1'b0;
                        if (d) begin
                            link_state = ST_ACK_RX;
                            shifter    = '0;
                        end
                        else begin
                            link_state = ST_ACK_TX;
                        end
                        bit_pos = '0;
                    end
                    ST_ACK_RX: begin
                        if (rx_fill >= DEPTH) begin
                            link_state = ST_IDLE;
                            line_en    = 1'b0;
                            line_val   = 1'b0;
                        end
                        else begin
                            line_en    = 1'b1;
                            line_val   = 1'b0;
                            link_state = ST_RX;
                        end
                        shifter = '0;
                        bit_pos = '0;
                    end
                    ST_RX: begin
                        line_en  = 1'b0;
                        line_val = 1'b0;
                        shifter[bit_pos[2:0]] = shifter[bit_pos[2:0]] | d;
                        bit_pos = bit_pos + 1'b1;
                        if (bit_pos >= BYTE_W) begin
                            if (rx_fill < DEPTH) begin
                                slot         = rx_head + rx_fill[PTR_W-1:0];
                                rx_mem[slot] = shifter;
                                rx_fill      = rx_fill + 1'b1;
                            end
                            link_state = ST_FIN_RX;
                        end
                    end
                    ST_FIN_RX: begin
                        line_en    = 1'b0;
                        line_val   = 1'b0;
                        link_state = d ? ST_IDLE : ST_ACK_RX;
                    end
                    ST_ACK_TX: begin
                        if (tx_fill != 0) begin
                            line_en      = 1'b1;
                            line_val     = 1'b0;
                            shifter      = tx_mem[tx_head];
                            tx_head      = tx_head + 1'b1;
                            tx_fill      = tx_fill - 1'b1;
                            bit_pos      = '0;
                            tx_tail_wait = 1'b0;
                            link_state   = ST_TX;
                        end
                        else begin
                            link_state = ST_IDLE;
                            line_en    = 1'b0;
                            line_val   = 1'b0;
                        end
                    end
                    ST_TX: begin
                        if (!tx_tail_wait) begin
                            line_en  = 1'b1;
                            line_val = shifter[bit_pos[2:0]];
                            bit_pos  = bit_pos + 1'b1;
                            if (bit_pos >= BYTE_W) tx_tail_wait = 1'b1;
                        end
                        else begin
                            line_en    = 1'b0;
                            line_val   = 1'b0;
                            link_state = d ? ST_IDLE : ST_ACK_TX;
                        end
                    end
                    default: ;
                endcase
            end
            CMD_PUSH: begin
                if (tx_fill < DEPTH) begin
                    slot         = tx_head + tx_fill[PTR_W-1:0];
                    tx_mem[slot] = b;
                    tx_fill      = tx_fill + 1'b1;
                    r.host_ok    = 1'b1;
                    host_hold    = !last;
                end
            end
            CMD_POP: begin
                if (rx_fill != 0) begin
                    r.host_byte_out = rx_mem[rx_head];
                    rx_head         = rx_head + 1'b1;
                    rx_fill         = rx_fill - 1'b1;
                    r.host_ok       = 1'b1;
                    host_hold       = !last;
                end
            end
            CMD_CLEAR: begin
                rx_head    = '0;
                rx_fill    = '0;
                tx_head    = '0;
                tx_fill    = '0;
                link_state = ST_IDLE;
                line_en    = 1'b0;
                line_val   = 1'b0;
                host_hold  = 1'b0;
            end
            CMD_TICK: begin
                if (idle_run != '1) idle_run = idle_run + 1'b1;
            end
            default: ;
        endcase
        r.drive_enable = line_en;
        r.drive_value  = line_en & line_val;
        r.read_fill    = rx_fill;
        r.send_fill    = tx_fill;
        r.bus_state    = link_state;
        r.idle_ticks   = idle_run;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            mismatch_total++;
            $display("%0t: %s expected 'h%0h, got 'h%0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : track_link
        link_result_t want;
        if (!rst_n) begin
            link_state   = ST_IDLE;
            tx_tail_wait = 1'b0;
            shifter      = '0;
            bit_pos      = '0;
            rx_head      = '0;
            tx_head      = '0;
            rx_fill      = '0;
            tx_fill      = '0;
            line_en      = 1'b0;
            line_val     = 1'b0;
            host_hold    = 1'b0;
            idle_run     = '0;
            for (int i = 0; i < DEPTH; i++) begin
                rx_mem[i] = '0;
                tx_mem[i] = '0;
            end
            expected_results.delete();
        end
        else begin
            if (in_valid && in_ready)
                expected_results.push_back(
                    next_link_result(cmd, clk_level, data_level, host_byte, host_last));
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    mismatch_total++;
                    $display("%0t: result beat with no event waiting for it", $time);
                end
                else begin
                    want = expected_results.pop_front();
                    compare_field("drive_enable", want.drive_enable, drive_enable);
                    compare_field("drive_value", want.drive_value, drive_value);
                    compare_field("host_ok", want.host_ok, host_ok);
                    compare_field("host_byte_out", want.host_byte_out, host_byte_out);
                    compare_field("read_fill", want.read_fill, read_fill);
                    compare_field("send_fill", want.send_fill, send_fill);
                    compare_field("bus_state", want.bus_state, bus_state);
                    compare_field("idle_ticks", want.idle_ticks, idle_ticks);
                end
            end
        end
        pending_total = expected_results.size();
    end

endmodule

/* tb/two_wire_serial_target_core_test.sv */
// Top of the two-wire serial target core testbench: clock, reset, event stimulus and verdict.
// Depends on tsc_pkg, the core and tsc_link_checker, which predicts and compares every beat.
`timescale 1ns / 100ps

module two_wire_serial_target_core_test;

    import tsc_pkg::*;

    localparam int CLK_PERIOD      = 8;
    localparam int RESET_CYCLES    = 12;
    localparam int ITEM_TARGET     = 1680;   // Directed beats plus about 1650 random ones.
    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int HOLD_OFF_AT     = 300;
    localparam int HOLD_OFF_CYCLES = 120;
    localparam int CALM_FROM       = 900;
    localparam int CALM_TO         = 1150;
    localparam int DRAIN_CYCLES    = 16;

    // Codes the core does not decode; it must leave its state alone on them.
    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [CMD_W-1:0]     cmd;
    logic                 clk_level;
    logic                 data_level;
    logic [BYTE_W-1:0]    host_byte;
    logic                 host_last;
    logic                 out_valid;
    logic                 out_ready;
    logic                 drive_enable;
    logic                 drive_value;
    logic                 host_ok;
    logic [BYTE_W-1:0]    host_byte_out;
    logic [FILL_W-1:0]    read_fill;
    logic [FILL_W-1:0]    send_fill;
    logic [STATE_W-1:0]   bus_state;
    logic [IDLE_W-1:0]    idle_ticks;

    int   mismatches;
    int   pending;
    int   items_sent = 0;
    int   stalled_cycles = 0;
    logic calm;

    // In the calm window neither side idles, so the core runs at its full beat rate.
    assign calm = (items_sent >= CALM_FROM) && (items_sent < CALM_TO);

    two_wire_serial_target_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .clk_level     (clk_level),
        .data_level    (data_level),
        .host_byte     (host_byte),
        .host_last     (host_last),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .drive_enable  (drive_enable),
        .drive_value   (drive_value),
        .host_ok       (host_ok),
        .host_byte_out (host_byte_out),
        .read_fill     (read_fill),
        .send_fill     (send_fill),
        .bus_state     (bus_state),
        .idle_ticks    (idle_ticks)
    );

    tsc_link_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .clk_level     (clk_level),
        .data_level    (data_level),
        .host_byte     (host_byte),
        .host_last     (host_last),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .drive_enable  (drive_enable),
        .drive_value   (drive_value),
        .host_ok       (host_ok),
        .host_byte_out (host_byte_out),
        .read_fill     (read_fill),
        .send_fill     (send_fill),
        .bus_state     (bus_state),
        .idle_ticks    (idle_ticks),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Offers one event beat. Fields change only at a falling edge, and the beat is held
    // until a rising edge sees in_ready. Outside the calm window the sender sometimes
    // drops valid first, so gaps land in every phase of a transaction.
    task automatic send_event(
        input logic [CMD_W-1:0]  op,
        input logic              ck,
        input logic              d,
        input logic [BYTE_W-1:0] b,
        input logic              last
    );
        int gap;
        @(negedge clk);
        if (!calm && $urandom_range(99) < 3) begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        cmd        <= op;
        clk_level  <= ck;
        data_level <= d;
        host_byte  <= b;
        host_last  <= last;
        do @(posedge clk); while (!in_ready);
        if (op <= CMD_TICK) items_sent++;
    endtask

    // A sampled clock rise with the given data level. Now and then a stray event is
    // slipped in first (abort, restart, clock-low edge or anything at all), which
    // breaks the transaction in progress at an arbitrary bit.
    task automatic bus_rise(input logic d);
        if ($urandom_range(199) == 0) begin
            case ($urandom_range(3))
                0: send_event(CMD_DATA_EDGE, 1'b1, 1'b1, 8'($urandom), 1'($urandom));
                1: send_event(CMD_DATA_EDGE, 1'b1, 1'b0, 8'($urandom), 1'($urandom));
                2: send_event(CMD_DATA_EDGE, 1'b0, 1'($urandom), 8'($urandom), 1'($urandom));
                default: send_event(3'($urandom_range(CMD_SPARE_B)), 1'($urandom),
                                    1'($urandom), 8'($urandom), 1'($urandom));
            endcase
        end
        send_event(CMD_CLK_RISE, 1'($urandom), d, 8'($urandom), 1'($urandom));
    endtask

    // A well-formed transaction as a host on the wires would run it: start, read/write
    // bit, then per byte an acknowledge slot, eight bits LSB first and a finish bit that
    // is high only after the last byte. Mostly short, sometimes long enough to overrun
    // a FIFO, which must end the transaction at the next acknowledge slot.
    task automatic bus_transaction(input logic to_target);
        int             n_bytes;
        int             i;
        int             k;
        logic [BYTE_W-1:0] payload;
        n_bytes = ($urandom_range(9) == 0) ? $urandom_range(5, 18) : $urandom_range(1, 4);
        send_event(CMD_DATA_EDGE, 1'b1, 1'b0, 8'($urandom), 1'($urandom));
        bus_rise(to_target);
        for (i = 0; i < n_bytes; i++) begin
            payload = 8'($urandom);
            // The target owns the line in the acknowledge slot; whatever is sampled is ignored.
            bus_rise(1'($urandom));
            for (k = 0; k < BYTE_W; k++)
                bus_rise(to_target ? payload[k] : 1'($urandom));
            bus_rise(i == n_bytes - 1);
        end
    endtask

    // Host-side FIFO traffic: runs of pushes, runs of pops, or a mix. A few accepted
    // beats leave the host transfer open, which must hold off the next start.
    task automatic host_burst();
        int   n_beats;
        int   mode;
        int   i;
        logic push;
        n_beats = ($urandom_range(9) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 8);
        mode    = $urandom_range(9);
        for (i = 0; i < n_beats; i++) begin
            push = (mode < 4) ? 1'b1 : (mode < 8) ? 1'b0 : 1'($urandom);
            send_event(push ? CMD_PUSH : CMD_POP, 1'($urandom), 1'($urandom), 8'($urandom),
                       $urandom_range(15) != 0);
        end
    endtask

    // Watchdog: any cycle with a beat on either channel restarts the count.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
        if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Result side. It takes beats with random stalls, none in the calm window, and once
    // refuses them for a long stretch while the sender keeps offering events, so the
    // core backs up and has to drop in_ready.
    initial begin : result_sink
        bit held_off;
        held_off  = 1'b0;
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (!held_off && items_sent >= HOLD_OFF_AT) begin
                held_off  = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            out_ready <= calm || ($urandom_range(99) >= 8);
        end
    end

    initial begin : event_source
        int pick;
        int i;
        clk        = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        cmd        = CMD_DATA_EDGE;
        clk_level  = 1'b0;
        data_level = 1'b0;
        host_byte  = '0;
        host_last  = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Directed opening. Idle count, the unused codes, refused and accepted host
        // beats, a start held off by an open host transfer, a clock-low edge, a rise
        // while idle, a restart in the middle of a transaction, a received all-ones
        // byte, a continue bit, an abort with data high, the pop of that byte and a
        // clear with bytes still queued for sending.
        send_event(CMD_TICK, 1'b1, 1'b1, 8'hFF, 1'b1);
        send_event(CMD_SPARE_A, 1'b1, 1'b0, 8'h5A, 1'b1);
        send_event(CMD_SPARE_B, 1'b0, 1'b1, 8'hA5, 1'b0);
        send_event(CMD_POP, 1'b0, 1'b0, 8'h00, 1'b1);
        send_event(CMD_PUSH, 1'b0, 1'b0, 8'h00, 1'b0);
        send_event(CMD_DATA_EDGE, 1'b1, 1'b0, 8'h00, 1'b0);
        send_event(CMD_PUSH, 1'b1, 1'b1, 8'hFF, 1'b1);
        send_event(CMD_DATA_EDGE, 1'b0, 1'b1, 8'h00, 1'b0);
        send_event(CMD_CLK_RISE, 1'b1, 1'b1, 8'h00, 1'b0);
        send_event(CMD_DATA_EDGE, 1'b1, 1'b0, 8'h00, 1'b0);
        send_event(CMD_DATA_EDGE, 1'b1, 1'b0, 8'hFF, 1'b1);
        send_event(CMD_CLK_RISE, 1'b0, 1'b1, 8'h00, 1'b0);
        send_event(CMD_CLK_RISE, 1'b0, 1'b0, 8'h00, 1'b0);
        for (i = 0; i < BYTE_W; i++)
            send_event(CMD_CLK_RISE, 1'b0, 1'b1, 8'h00, 1'b0);
        send_event(CMD_CLK_RISE, 1'b1, 1'b0, 8'h00, 1'b0);
        send_event(CMD_CLK_RISE, 1'b1, 1'b1, 8'h00, 1'b0);
        send_event(CMD_DATA_EDGE, 1'b1, 1'b1, 8'h00, 1'b0);
        send_event(CMD_POP, 1'b0, 1'b0, 8'h00, 1'b1);
        send_event(CMD_CLEAR, 1'b1, 1'b1, 8'hFF, 1'b1);

        // Random part: mostly well-formed transactions in both directions and host
        // traffic, which keeps both FIFOs wandering between empty and full, plus noise.
        // The idle counter's saturation at all ones needs 2**32 - 1 ticks and stays out of reach.
        while (items_sent < ITEM_TARGET) begin
            pick = $urandom_range(99);
            if (pick < 30)
                bus_transaction(1'b1);
            else if (pick < 55)
                bus_transaction(1'b0);
            else if (pick < 90)
                host_burst();
            else
                repeat ($urandom_range(1, 3))
                    send_event(3'($urandom_range(CMD_SPARE_B)), 1'($urandom), 1'($urandom),
                               8'($urandom), 1'($urandom));
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(1, 3))
                    send_event(CMD_TICK, 1'($urandom), 1'($urandom), 8'($urandom),
                               1'($urandom));
        end

        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/tsc_pkg.sv
hw/rtl/tsc_ram.sv
hw/rtl/tsc_ctrl.sv
hw/rtl/tsc_outq.sv
hw/rtl/two_wire_serial_target_core.sv
hw/rtl/tsc_checker.sv
tb/tsc_link_checker.sv
tb/two_wire_serial_target_core_test.sv
